// ===== hw/rtl/les_pkg.sv =====
// Shared types, constants and helper functions for the Lorenz Euler step unit.
package les_pkg;

    localparam int COORD_W    = 32;
    localparam int OP_W       = 34;
    localparam int PROD_W     = 64;
    localparam int RATE_W     = 48;
    localparam int COEF_W     = 31;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RHO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd6;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [OP_W-1:0]    t_op;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [RATE_W-1:0]  t_rate;
    typedef logic [COEF_W-1:0]         t_coef;
    typedef logic [STEP_W-1:0]         t_step;

    localparam t_prod RATE_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam t_prod RATE_MIN  = 64'shFFFF_8000_0000_0000;
    localparam t_prod COORD_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam t_prod COORD_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        t_coef  sigma;
        t_coef  rho;
        t_coef  beta;
        t_step  step_size;
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul1;
        logic mul2;
        logic rate;
        logic adv_x;
        logic adv_y;
        logic adv_z;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_rate value;
        logic  sat;
    } t_rate_clip;

    typedef struct packed {
        t_coord value;
        logic   sat;
    } t_coord_clip;

    function automatic t_rate_clip clip_rate(input t_prod v);
        t_rate_clip r;
        if (v > RATE_MAX) begin
            r.value = RATE_MAX[RATE_W-1:0];
            r.sat   = 1'b1;
        end else if (v < RATE_MIN) begin
            r.value = RATE_MIN[RATE_W-1:0];
            r.sat   = 1'b1;
        end else begin
            r.value = v[RATE_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    function automatic t_coord_clip clip_coord(input t_prod v);
        t_coord_clip r;
        if (v > COORD_MAX) begin
            r.value = COORD_MAX[COORD_W-1:0];
            r.sat   = 1'b1;
        end else if (v < COORD_MIN) begin
            r.value = COORD_MIN[COORD_W-1:0];
            r.sat   = 1'b1;
        end else begin
            r.value = v[COORD_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    function automatic t_coef rst_sigma(input int frac);
        longint one;
        one = longint'(1) << frac;
        return COEF_W'(10 * one);
    endfunction

    function automatic t_coef rst_rho(input int frac);
        longint one;
        one = longint'(1) << frac;
        return COEF_W'(28 * one);
    endfunction

    function automatic t_coef rst_beta(input int frac);
        longint one;
        one = longint'(1) << frac;
        return COEF_W'((16 * one + 3) / 6);
    endfunction

    function automatic t_step rst_step(input int frac);
        longint one;
        one = longint'(1) << frac;
        return STEP_W'((2 * one + 100) / 200);
    endfunction

    function automatic t_coord rst_start_x(input int frac);
        longint one;
        one = longint'(1) << frac;
        return COORD_W'((2 * one + 100) / 200);
    endfunction

endpackage

// ===== hw/rtl/les_if.sv =====
// Handshake channel interfaces for input items, result items and register writes.
interface les_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface les_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  point_z;
    logic                saturated;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output saturated, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input saturated, output ready);
endinterface

interface les_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/lorenz_euler_step_unit.sv =====
// Lorenz system Euler step unit: one new point per input item, Q16.16 fixed point.
// Each accepted item advances the point (x, y, z) by one explicit Euler step,
// optionally reloading the configured start point first, and yields one result
// with the new point and a saturation flag. From one acceptance to the next an item
// steps through S_IDLE, which accepts it and reloads the start point on a
// restart, S_PREP to prepare operands, S_MUL1 and S_MUL2 on a pair of 34x34
// coefficient multipliers for the four rate products, S_RATE, S_ADV_X and S_ADV_Y
// on one 48x17 step multiplier that scales each rate by the step size, S_ADV_Z for
// the last coordinate update, and S_EMIT to load the output register. The result
// sits in an output register, so the next item is accepted while it waits to be
// taken; a new result is held back only until the previous one has been taken.
// Registers must be written by the user through the configuration channel only
// while no item is in flight; the block itself does not enforce this.
module lorenz_euler_step_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    les_in_if.sink      i_in,
    les_out_if.source   o_out,
    les_cfg_if.sink     i_cfg
);

    les_pkg::t_cfg    w_cfg;
    les_pkg::t_dp_cmd w_cmd;
    logic             w_in_ready;
    logic             w_out_valid;

    les_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    les_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    les_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_restart   (i_in.restart),
        .i_cfg       (w_cfg),
        .o_point_x   (o_out.point_x),
        .o_point_y   (o_out.point_y),
        .o_point_z   (o_out.point_z),
        .o_saturated (o_out.saturated)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

// ===== hw/rtl/les_cfg_regs.sv =====
// Configuration register file: coefficients, step size and start point.
module les_cfg_regs #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    les_cfg_if.sink         i_cfg,
    output les_pkg::t_cfg   o_cfg
);

    les_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sigma     <= les_pkg::rst_sigma(FRAC_BITS);
            r_cfg.rho       <= les_pkg::rst_rho(FRAC_BITS);
            r_cfg.beta      <= les_pkg::rst_beta(FRAC_BITS);
            r_cfg.step_size <= les_pkg::rst_step(FRAC_BITS);
            r_cfg.start_x   <= les_pkg::rst_start_x(FRAC_BITS);
            r_cfg.start_y   <= '0;
            r_cfg.start_z   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                les_pkg::CFG_SIGMA:   r_cfg.sigma     <= i_cfg.data[les_pkg::COEF_W-1:0];
                les_pkg::CFG_RHO:     r_cfg.rho       <= i_cfg.data[les_pkg::COEF_W-1:0];
                les_pkg::CFG_BETA:    r_cfg.beta      <= i_cfg.data[les_pkg::COEF_W-1:0];
                les_pkg::CFG_STEP:    r_cfg.step_size <= i_cfg.data[les_pkg::STEP_W-1:0];
                les_pkg::CFG_START_X: r_cfg.start_x   <= i_cfg.data;
                les_pkg::CFG_START_Y: r_cfg.start_y   <= i_cfg.data;
                les_pkg::CFG_START_Z: r_cfg.start_z   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/les_datapath.sv =====
// Datapath: point registers, two coefficient multipliers, step multiplier, clamps.
module les_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  les_pkg::t_dp_cmd  i_cmd,
    input  logic              i_restart,
    input  les_pkg::t_cfg     i_cfg,
    output les_pkg::t_coord   o_point_x,
    output les_pkg::t_coord   o_point_y,
    output les_pkg::t_coord   o_point_z,
    output logic              o_saturated
);

    les_pkg::t_coord r_cur_x;
    les_pkg::t_coord r_cur_y;
    les_pkg::t_coord r_cur_z;
    les_pkg::t_op    r_ma_a;
    les_pkg::t_op    r_ma_b;
    les_pkg::t_op    r_mb_a;
    les_pkg::t_op    r_mb_b;
    les_pkg::t_prod  r_pa;
    les_pkg::t_prod  r_pb;
    les_pkg::t_rate  r_rx;
    les_pkg::t_rate  r_ry;
    les_pkg::t_rate  r_rz;
    les_pkg::t_prod  r_sp;
    logic            r_sat;
    les_pkg::t_coord r_out_x;
    les_pkg::t_coord r_out_y;
    les_pkg::t_coord r_out_z;
    logic            r_out_sat;

    logic signed [2*les_pkg::OP_W-1:0]                  w_pa_full;
    logic signed [2*les_pkg::OP_W-1:0]                  w_pb_full;
    logic signed [les_pkg::RATE_W+les_pkg::STEP_W:0]    w_sp_full;
    logic signed [les_pkg::STEP_W:0]                    w_step_s;
    les_pkg::t_rate       w_rate_op;
    les_pkg::t_prod       n_pa;
    les_pkg::t_prod       n_pb;
    les_pkg::t_prod       n_sp;
    les_pkg::t_prod       w_fs_pa;
    les_pkg::t_prod       w_fs_pb;
    les_pkg::t_prod       w_fs_sp;
    les_pkg::t_op         w_x_op;
    les_pkg::t_op         w_y_op;
    les_pkg::t_op         w_z_op;
    les_pkg::t_prod       w_y_ext;
    les_pkg::t_coord      w_adv_cur;
    les_pkg::t_prod       w_adv_sum;
    les_pkg::t_rate_clip  w_clip_a;
    les_pkg::t_rate_clip  w_clip_b;
    les_pkg::t_rate_clip  w_clip_z;
    les_pkg::t_coord_clip w_clip_c;

    assign w_pa_full = r_ma_a * r_ma_b;
    assign w_pb_full = r_mb_a * r_mb_b;
    assign n_pa      = w_pa_full[les_pkg::PROD_W-1:0];
    assign n_pb      = w_pb_full[les_pkg::PROD_W-1:0];
    assign w_fs_pa   = r_pa >>> FRAC_BITS;
    assign w_fs_pb   = r_pb >>> FRAC_BITS;
    assign w_fs_sp   = r_sp >>> FRAC_BITS;

    assign w_x_op  = les_pkg::OP_W'(r_cur_x);
    assign w_y_op  = les_pkg::OP_W'(r_cur_y);
    assign w_z_op  = les_pkg::OP_W'(r_cur_z);
    assign w_y_ext = les_pkg::PROD_W'(r_cur_y);

    assign w_clip_a = les_pkg::clip_rate(w_fs_pa);
    assign w_clip_b = les_pkg::clip_rate(w_fs_pb - w_y_ext);
    assign w_clip_z = les_pkg::clip_rate(w_fs_pa - w_fs_pb);

    always_comb begin
        if (i_cmd.adv_x) begin
            w_rate_op = r_ry;
        end else if (i_cmd.adv_y) begin
            w_rate_op = r_rz;
        end else begin
            w_rate_op = r_rx;
        end
    end

    assign w_step_s  = {1'b0, i_cfg.step_size};
    assign w_sp_full = w_rate_op * w_step_s;
    assign n_sp      = w_sp_full[les_pkg::PROD_W-1:0];

    always_comb begin
        if (i_cmd.adv_x) begin
            w_adv_cur = r_cur_x;
        end else if (i_cmd.adv_y) begin
            w_adv_cur = r_cur_y;
        end else begin
            w_adv_cur = r_cur_z;
        end
    end

    assign w_adv_sum = w_fs_sp + les_pkg::PROD_W'(w_adv_cur);
    assign w_clip_c  = les_pkg::clip_coord(w_adv_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= les_pkg::rst_start_x(FRAC_BITS);
            r_cur_y <= '0;
            r_cur_z <= '0;
        end else if (i_cmd.load && i_restart) begin
            r_cur_x <= i_cfg.start_x;
            r_cur_y <= i_cfg.start_y;
            r_cur_z <= i_cfg.start_z;
        end else if (i_cmd.adv_x) begin
            r_cur_x <= w_clip_c.value;
        end else if (i_cmd.adv_y) begin
            r_cur_y <= w_clip_c.value;
        end else if (i_cmd.adv_z) begin
            r_cur_z <= w_clip_c.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_ma_a <= les_pkg::OP_W'(i_cfg.sigma);
            r_ma_b <= w_y_op - w_x_op;
            r_mb_a <= w_x_op;
            r_mb_b <= les_pkg::OP_W'(i_cfg.rho) - w_z_op;
        end else if (i_cmd.mul1) begin
            r_ma_a <= w_x_op;
            r_ma_b <= w_y_op;
            r_mb_a <= les_pkg::OP_W'(i_cfg.beta);
            r_mb_b <= w_z_op;
        end
        if (i_cmd.mul1 || i_cmd.mul2) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
        if (i_cmd.mul2) begin
            r_rx <= w_clip_a.value;
            r_ry <= w_clip_b.value;
        end
        if (i_cmd.rate) begin
            r_rz <= w_clip_z.value;
        end
        if (i_cmd.rate || i_cmd.adv_x || i_cmd.adv_y) begin
            r_sp <= n_sp;
        end
        if (i_cmd.prep) begin
            r_sat <= 1'b0;
        end else if (i_cmd.mul2) begin
            r_sat <= r_sat | w_clip_a.sat | w_clip_b.sat;
        end else if (i_cmd.rate) begin
            r_sat <= r_sat | w_clip_z.sat;
        end else if (i_cmd.adv_x || i_cmd.adv_y || i_cmd.adv_z) begin
            r_sat <= r_sat | w_clip_c.sat;
        end
        if (i_cmd.emit) begin
            r_out_x   <= r_cur_x;
            r_out_y   <= r_cur_y;
            r_out_z   <= r_cur_z;
            r_out_sat <= r_sat;
        end
    end

    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_point_z   = r_out_z;
    assign o_saturated = r_out_sat;

endmodule

// ===== hw/rtl/les_ctrl.sv =====
// Controller: sequences one Euler step and owns the input and result handshakes.
module les_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output les_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_RATE  = 4'd4;
    localparam logic [3:0] S_ADV_X = 4'd5;
    localparam logic [3:0] S_ADV_Y = 4'd6;
    localparam logic [3:0] S_ADV_Z = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_RATE;
            end
            S_RATE: begin
                o_cmd.rate = 1'b1;
                n_state    = S_ADV_X;
            end
            S_ADV_X: begin
                o_cmd.adv_x = 1'b1;
                n_state     = S_ADV_Y;
            end
            S_ADV_Y: begin
                o_cmd.adv_y = 1'b1;
                n_state     = S_ADV_Z;
            end
            S_ADV_Z: begin
                o_cmd.adv_z = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.emit | (r_out_valid & ~i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
